### rtl/core/fwrs_pkg.sv
// Shared types and constants for the flow window rate summary block.
`timescale 1ns / 1ps

package fwrs_pkg;

  localparam int MAX_WINDOWS_DEF = 64;
  localparam int CNT_W           = 11;
  localparam int QDEPTH          = 2;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP    = 1'b1;

  localparam logic [31:0] RATE_SCALE_RST = 32'd1000;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_EVIDENCE   = 3'd1,
    ST_INVERTED      = 3'd2,
    ST_ZERO_LENGTH   = 3'd3,
    ST_ZERO_DURATION = 3'd4,
    ST_OVERFLOW      = 3'd5
  } status_t;

  typedef struct packed {
    logic [63:0] span_begin;
    logic [63:0] span_end;
    logic [63:0] win_bytes;
    logic [2:0]  svc_class;
    logic [1:0]  protection;
    logic        priority_known;
    logic        gap_seen_before;
    logic        flow_completed;
    logic [63:0] windows_dropped;
    logic        no_samples;
    logic        last_window;
  } item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             contiguous;
    logic             gap_found;
    logic             completed;
    logic             all_known;
    logic [63:0]      observed_begin;
    logic [63:0]      span_ticks;
    logic [63:0]      retained_bytes;
    logic [63:0]      avg_rate;
    logic [63:0]      peak_rate;
    logic [CNT_W-1:0] window_total;
    logic [63:0]      dropped_count;
  } result_t;

  typedef enum logic {
    KIND_WINDOW = 1'b0,
    KIND_EMPTY  = 1'b1
  } item_kind_t;

  // Classified queue entry: kind and window length are settled at the front
  typedef struct packed {
    item_kind_t  kind;
    logic [63:0] len;
    item_t       item;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [31:0] b;
    logic [63:0] d;
  } div_req_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic        ovf;
    logic [63:0] q;
  } div_resp_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MLO,
    DV_MHI,
    DV_CHK,
    DV_RUN,
    DV_DONE
  } div_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PEAK,
    BK_FINAL,
    BK_SUST,
    BK_EMIT
  } back_state_t;

endpackage

### rtl/core/flow_window_rate_summary.sv
// Top level of the flow window rate summary block: configuration and instances.
`timescale 1ns / 1ps

// Summarizes one flow's evidence windows, one window per input transaction,
// and produces one result on the item marked last (or on an empty-set item).
// A two-entry input queue decouples acceptance from processing, and a result
// register holds the finished summary until popped, so the input side keeps
// accepting while a result waits. Each window with nonzero length goes through
// the shared multiply/divide unit (32x32 partial products and a range check,
// then one quotient bit per cycle, plus handoff); a zero-length window skips
// the unit. The last window adds a second pass through the same unit for the
// sustained rate when its final checks pass. Throughput is set by that single
// divider.
module flow_window_rate_summary
  import fwrs_pkg::*;
#(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  item_t                item,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [31:0] rate_scale;
  logic [63:0] gap_limit;
  logic        q_valid;
  q_entry_t    head;
  logic        q_pop;
  div_req_t    div_req;
  div_resp_t   div_resp;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale <= RATE_SCALE_RST;
      gap_limit  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATE_SCALE: rate_scale <= cfg_data[31:0];
        CFG_MAX_GAP:    gap_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  fwrs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .head    (head),
    .q_pop   (q_pop)
  );

  fwrs_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  fwrs_back #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .q_pop      (q_pop),
    .rate_scale (rate_scale),
    .gap_limit  (gap_limit),
    .div_req    (div_req),
    .div_resp   (div_resp),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

### rtl/core/fwrs_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module fwrs_front
  import fwrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  item_t    item,
  output logic     q_valid,
  output q_entry_t head,
  input  logic     q_pop
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  q_entry_t          mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  q_entry_t          entry;
  logic              do_push;
  logic              do_pop;

  // Classify the incoming transaction and work out its window length
  always_comb begin
    entry.item = item;
    entry.kind = item.no_samples ? KIND_EMPTY : KIND_WINDOW;
    entry.len  = (item.span_end > item.span_begin) ? (item.span_end - item.span_begin) : 64'd0;
  end

  assign full    = (count == CNT_QW'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/fwrs_muldiv.sv
// Shared unit: floor(a * b / d) with a 64x32 multiply and a bit-serial 128/64 divide.
`timescale 1ns / 1ps

module fwrs_muldiv
  import fwrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  div_state_t   state;
  div_state_t   state_next;
  logic [63:0]  a_q;
  logic [31:0]  b_q;
  logic [63:0]  d_q;
  logic [63:0]  plo;
  logic [63:0]  phi;
  logic [63:0]  rem;
  logic [63:0]  lo;
  logic [5:0]   cnt;
  logic         ovf;
  logic [127:0] prod;
  logic         hi_over;
  logic [63:0]  shifted;
  logic         take;
  logic [63:0]  rem_step;

  // Combine partial products and run one restoring step
  always_comb begin
    prod     = {32'd0, phi, 32'd0} + {64'd0, plo};
    hi_over  = (d_q == 64'd0) || (prod[127:64] >= d_q);
    shifted  = {rem[62:0], lo[63]};
    take     = rem[63] || (shifted >= d_q);
    rem_step = take ? (shifted - d_q) : shifted;
  end

  // Sequence multiply, range check and divide
  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: if (req.start) begin
        state_next = DV_MLO;
      end
      DV_MLO:  state_next = DV_MHI;
      DV_MHI:  state_next = DV_CHK;
      DV_CHK:  state_next = hi_over ? DV_DONE : DV_RUN;
      DV_RUN: if (cnt == 6'd63) begin
        state_next = DV_DONE;
      end
      DV_DONE: state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
    resp.idle = (state == DV_IDLE);
    resp.done = (state == DV_DONE);
    resp.ovf  = ovf;
    resp.q    = lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: if (req.start) begin
        a_q <= req.a;
        b_q <= req.b;
        d_q <= req.d;
      end
      DV_MLO: plo <= {32'd0, a_q[31:0]} * {32'd0, b_q};
      DV_MHI: phi <= {32'd0, a_q[63:32]} * {32'd0, b_q};
      DV_CHK: begin
        rem <= prod[127:64];
        lo  <= prod[63:0];
        ovf <= hi_over;
        cnt <= 6'd0;
      end
      DV_RUN: begin
        rem <= rem_step;
        lo  <= {lo[62:0], take};
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/fwrs_back.sv
// Back end: folds windows into running state, drives the divider, holds the result.
`timescale 1ns / 1ps

module fwrs_back
  import fwrs_pkg::*;
#(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  q_entry_t    head,
  output logic        q_pop,
  input  logic [31:0] rate_scale,
  input  logic [63:0] gap_limit,
  output div_req_t    div_req,
  input  div_resp_t   div_resp,
  output logic        empty,
  input  logic        pop,
  output result_t     result
);

  back_state_t      state;
  back_state_t      state_next;
  logic [63:0]      first_begin;
  logic [63:0]      previous_end;
  logic [63:0]      byte_sum;
  logic [63:0]      peak_so_far;
  logic [CNT_W-1:0] window_counter;
  logic             adjoining_flag;
  logic             gap_flag;
  logic             zero_length_flag;
  item_t            cur;
  result_t          res;
  result_t          out_res;
  logic             out_valid;
  logic             out_free;
  logic             clear_now;

  item_t            h;
  logic [63:0]      fb_new;
  logic             adj_new;
  logic             gap_new;
  logic [64:0]      sum_wide;
  logic [63:0]      sum_sat;
  logic [63:0]      rate_val;
  logic [63:0]      duration;
  logic [2:0]       final_status;
  logic             gap_any;
  result_t          empty_res;
  result_t          err_res;
  result_t          ok_res;

  // Fold the head window into the running state
  always_comb begin
    h        = head.item;
    fb_new   = (window_counter == '0) ? h.span_begin : first_begin;
    adj_new  = adjoining_flag;
    gap_new  = gap_flag;
    if (window_counter != '0) begin
      if (h.span_begin != previous_end) begin
        adj_new = 1'b0;
      end
      if ((gap_limit != 64'd0) && (h.span_begin > previous_end) &&
          ((h.span_begin - previous_end) > gap_limit)) begin
        gap_new = 1'b1;
      end
    end
    sum_wide = {1'b0, byte_sum} + {1'b0, h.win_bytes};
    sum_sat  = sum_wide[64] ? '1 : sum_wide[63:0];
    rate_val = div_resp.ovf ? '1 : div_resp.q;
  end

  // Final checks and the three result shapes
  always_comb begin
    duration = cur.span_end - first_begin;
    if (cur.span_end < first_begin) begin
      final_status = ST_INVERTED;
    end else if (zero_length_flag) begin
      final_status = ST_ZERO_LENGTH;
    end else if (duration == 64'd0) begin
      final_status = ST_ZERO_DURATION;
    end else begin
      final_status = ST_OK;
    end
    gap_any = cur.gap_seen_before || gap_flag;

    empty_res               = '0;
    empty_res.status        = ST_NO_EVIDENCE;
    empty_res.completed     = h.flow_completed;
    empty_res.dropped_count = h.windows_dropped;

    err_res                 = '0;
    err_res.status          = (state == BK_SUST) ? ST_OVERFLOW : final_status;
    err_res.completed       = cur.flow_completed;
    err_res.dropped_count   = cur.windows_dropped;

    ok_res                = '0;
    ok_res.status         = ST_OK;
    ok_res.contiguous     = (window_counter >= CNT_W'(2)) && adjoining_flag && !gap_any;
    ok_res.gap_found      = gap_any;
    ok_res.completed      = cur.flow_completed;
    ok_res.all_known      = !gap_any && (cur.svc_class != 3'd0) &&
                            (cur.protection != 2'd0) && cur.priority_known;
    ok_res.observed_begin = first_begin;
    ok_res.span_ticks     = duration;
    ok_res.retained_bytes = byte_sum;
    ok_res.avg_rate       = div_resp.q;
    ok_res.peak_rate      = peak_so_far;
    ok_res.window_total   = window_counter;
    ok_res.dropped_count  = cur.windows_dropped;
  end

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign result   = out_res;

  // Next state, queue pop and divider requests
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    clear_now   = 1'b0;
    div_req     = '0;
    div_req.b   = rate_scale;
    div_req.a   = h.win_bytes;
    div_req.d   = head.len;
    case (state)
      BK_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (head.kind == KIND_EMPTY) begin
          clear_now  = 1'b1;
          state_next = BK_EMIT;
        end else if (head.len != 64'd0) begin
          div_req.start = 1'b1;
          state_next    = BK_PEAK;
        end else if (h.last_window) begin
          state_next = BK_FINAL;
        end
      end
      BK_PEAK: if (div_resp.done) begin
        state_next = cur.last_window ? BK_FINAL : BK_IDLE;
      end
      BK_FINAL: begin
        if (final_status != ST_OK) begin
          clear_now  = 1'b1;
          state_next = BK_EMIT;
        end else begin
          div_req.start = 1'b1;
          div_req.a     = byte_sum;
          div_req.d     = duration;
          state_next    = BK_SUST;
        end
      end
      BK_SUST: if (div_resp.done) begin
        clear_now  = 1'b1;
        state_next = BK_EMIT;
      end
      BK_EMIT: if (out_free) begin
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Running state, result capture and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      first_begin      <= '0;
      previous_end     <= '0;
      byte_sum         <= '0;
      peak_so_far      <= '0;
      window_counter   <= '0;
      adjoining_flag   <= 1'b1;
      gap_flag         <= 1'b0;
      zero_length_flag <= 1'b0;
    end else begin
      // Load the output register when it frees up, otherwise drop it on pop
      if ((state == BK_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: if (q_valid) begin
          cur <= h;
          if (head.kind == KIND_EMPTY) begin
            res <= empty_res;
          end else begin
            first_begin    <= fb_new;
            adjoining_flag <= adj_new;
            gap_flag       <= gap_new;
            byte_sum       <= sum_sat;
            previous_end   <= h.span_end;
            if (head.len == 64'd0) begin
              zero_length_flag <= 1'b1;
            end
            if (window_counter < CNT_W'(MAX_WINDOWS)) begin
              window_counter <= window_counter + 1'b1;
            end
          end
        end
        BK_PEAK: if (div_resp.done && (rate_val > peak_so_far)) begin
          peak_so_far <= rate_val;
        end
        BK_FINAL: if (final_status != ST_OK) begin
          res <= err_res;
        end
        BK_SUST: if (div_resp.done) begin
          res <= div_resp.ovf ? err_res : ok_res;
        end
        BK_EMIT: if (out_free) begin
          out_res <= res;
        end
        default: ;
      endcase
      // Drop the running state once a result is formed
      if (clear_now) begin
        first_begin      <= '0;
        previous_end     <= '0;
        byte_sum         <= '0;
        peak_so_far      <= '0;
        window_counter   <= '0;
        adjoining_flag   <= 1'b1;
        gap_flag         <= 1'b0;
        zero_length_flag <= 1'b0;
      end
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> div_resp.idle)
    else $error("divider started while busy");

  a_ok_has_duration: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.status == ST_OK)) |-> (out_res.span_ticks != 64'd0))
    else $error("ok result with zero duration");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.status != ST_OK)) |->
    ((out_res.avg_rate == 64'd0) && (out_res.window_total == '0)))
    else $error("error result carries rate fields");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    window_counter <= CNT_W'(MAX_WINDOWS))
    else $error("window counter past its limit");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> ((state == BK_IDLE) && q_valid))
    else $error("queue popped outside idle");

endmodule
